// ===== rtl/core/hcep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcep_pkg
// Shared types and constants for the Huffman encoder and bit packer.
// ----------------------------------------------------------------------------
package hcep_pkg;

  // Table geometry
  localparam int SymbolCount = 256;
  localparam int MaxCodeLen  = 32;
  localparam int IdxW        = (SymbolCount > 1) ? $clog2(SymbolCount) : 1;
  localparam int CapLen      = (MaxCodeLen < 32) ? MaxCodeLen : 32;

  // Field widths
  localparam int SymW   = 8;
  localparam int CodeW  = 32;
  localparam int LenW   = 6;
  localparam int TotalW = 40;
  localparam int EntryW = LenW + CodeW;

  // Request codes; the fourth code is ignored
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_PAD     = 2'd1,
    KIND_END     = 2'd2,
    KIND_MISSING = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [SymW-1:0] symbol;
    logic [CodeW-1:0] code_bits;
    logic [LenW-1:0] code_length;
    logic            entry_present;
  } hcep_in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic [1:0]        result_kind;
    logic [TotalW-1:0] bit_total;
    logic              last;
  } hcep_out_t;

  // Table lookup result handed to the packer
  typedef struct packed {
    logic [1:0]       req;
    logic             hit;
    logic [LenW-1:0]  length;
    logic [CodeW-1:0] code;
  } hcep_look_t;

  // Burst of results handed to the emitter, first byte in the top bits
  typedef struct packed {
    logic [2:0]        count;
    logic [31:0]       bytes;
    logic [1:0]        kind;
    logic [TotalW-1:0] total;
  } hcep_burst_t;

endpackage
`default_nettype wire

// ===== rtl/core/hcep_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcep_table
// Code table memory with per-entry present flags and the lookup stage.
// ----------------------------------------------------------------------------
module hcep_table
  import hcep_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire hcep_in_t   item_i,
  input  wire logic       advance_i,
  output logic            look_valid_o,
  output hcep_look_t      look_o
);

  logic [EntryW-1:0]      mem_q [SymbolCount];
  logic [EntryW-1:0]      rd_q;
  logic [SymbolCount-1:0] present_q, present_d;
  logic                   valid_q, valid_d;
  logic [1:0]             req_q;
  logic                   hit_q;

  logic [IdxW-1:0] idx;
  logic            in_range;
  logic [LenW-1:0] len_sat;
  logic            is_load;

  assign idx      = item_i.symbol[IdxW-1:0];
  assign in_range = ({1'b0, item_i.symbol} < (SymW + 1)'(SymbolCount));
  assign len_sat  = (item_i.code_length > LenW'(CapLen)) ? LenW'(CapLen)
                                                         : item_i.code_length;
  assign is_load  = take_i && (item_i.req_type == REQ_LOAD) && in_range;

  // Table memory: load writes, every item reads its entry
  always_ff @(posedge clk_i) begin
    if (is_load) begin
      mem_q[idx] <= {len_sat, item_i.code_bits};
    end
    if (take_i) begin
      rd_q <= mem_q[idx];
    end
  end

  // Present flags, cleared at reset
  always_comb begin
    present_d = present_q;
    if (is_load) begin
      present_d[idx] = item_i.entry_present;
    end
  end

  // Lookup stage control
  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      present_q <= present_d;
      valid_q   <= valid_d;
    end
  end

  // Lookup stage payload
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      req_q <= item_i.req_type;
      hit_q <= in_range && present_q[idx];
    end
  end

  assign look_valid_o  = valid_q;
  assign look_o.req    = req_q;
  assign look_o.hit    = hit_q;
  assign look_o.length = rd_q[EntryW-1:CodeW];
  assign look_o.code   = rd_q[CodeW-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/hcep_pack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcep_pack
// Bit packer: joins pending bits with the looked-up code, cuts whole bytes,
// keeps the running bit total and builds the result burst of each item.
// ----------------------------------------------------------------------------
module hcep_pack
  import hcep_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        look_valid_i,
  input  wire hcep_look_t  look_i,
  input  wire logic        emit_free_i,
  output logic             advance_o,
  output logic             burst_load_o,
  output hcep_burst_t      burst_o
);

  logic [6:0]        pend_q, pend_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [TotalW-1:0] total_q, total_d;

  logic [TotalW:0]   sum;
  logic [TotalW-1:0] total_sat;
  logic [39:0]       mask, joined, aligned;
  logic [5:0]        nbits;
  logic [2:0]        nbytes, rem;
  logic [31:0]       enc_bytes;
  logic [6:0]        new_pend;
  logic [7:0]        pad_byte;

  // Saturating bit total
  assign sum       = {1'b0, total_q} + (TotalW + 1)'(look_i.length);
  assign total_sat = sum[TotalW] ? '1 : sum[TotalW-1:0];

  // Pending bits followed by the code, right-aligned
  assign mask    = ~({40{1'b1}} << look_i.length);
  assign joined  = ({33'b0, pend_q} << look_i.length) | ({8'b0, look_i.code} & mask);
  assign nbits   = 6'(cnt_q) + look_i.length;
  assign nbytes  = nbits[5:3];
  assign rem     = nbits[2:0];
  assign aligned = joined >> rem;
  assign enc_bytes = aligned[31:0] << {3'd4 - nbytes, 3'b000};
  assign new_pend  = joined[6:0] & ~(7'h7f << rem);

  // Final partial byte, zero-padded on the right
  assign pad_byte = {pend_q, 1'b0} << (3'd7 - cnt_q);

  always_comb begin
    pend_d        = pend_q;
    cnt_d         = cnt_q;
    total_d       = total_q;
    burst_o.count = 3'd0;
    burst_o.bytes = '0;
    burst_o.kind  = KIND_BYTE;
    burst_o.total = total_q;
    unique case (look_i.req)
      REQ_ENCODE: begin
        if (!look_i.hit) begin
          burst_o.count = 3'd1;
          burst_o.kind  = KIND_MISSING;
        end else begin
          burst_o.count = nbytes;
          burst_o.bytes = enc_bytes;
          burst_o.total = total_sat;
          pend_d        = new_pend;
          cnt_d         = rem;
          total_d       = total_sat;
        end
      end
      REQ_FLUSH: begin
        burst_o.count = 3'd1;
        if (cnt_q != 3'd0) begin
          burst_o.kind  = KIND_PAD;
          burst_o.bytes = {pad_byte, 24'b0};
        end else begin
          burst_o.kind  = KIND_END;
        end
        pend_d  = '0;
        cnt_d   = '0;
        total_d = '0;
      end
      default: begin
        // load or unknown request: no results, packer state untouched
      end
    endcase
  end

  // Items without results need no room in the emitter
  assign advance_o    = look_valid_i && ((burst_o.count == 3'd0) || emit_free_i);
  assign burst_load_o = advance_o && (burst_o.count != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      cnt_q   <= '0;
      total_q <= '0;
    end else if (advance_o) begin
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/hcep_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcep_emit
// Output register: holds a burst of up to four results and hands them out
// one byte per item, first byte first.
// ----------------------------------------------------------------------------
module hcep_emit
  import hcep_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire hcep_burst_t burst_i,
  input  wire logic        out_stall_i,
  output logic             free_o,
  output logic             out_valid_o,
  output hcep_out_t        out_item_o
);

  logic [2:0]        cnt_q, cnt_d;
  logic [31:0]       bytes_q;
  logic [1:0]        kind_q;
  logic [TotalW-1:0] total_q;
  logic              take;

  assign take   = (cnt_q != 3'd0) && !out_stall_i;
  assign free_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && take);

  // Result count
  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = burst_i.count;
    end else if (take) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload: load a new burst or step to the next byte
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= burst_i.bytes;
      kind_q  <= burst_i.kind;
      total_q <= burst_i.total;
    end else if (take) begin
      bytes_q <= {bytes_q[23:0], 8'b0};
    end
  end

  assign out_valid_o            = (cnt_q != 3'd0);
  assign out_item_o.out_byte    = bytes_q[31:24];
  assign out_item_o.result_kind = kind_q;
  assign out_item_o.bit_total   = total_q;
  assign out_item_o.last        = (cnt_q == 3'd1);

endmodule
`default_nettype wire

// ===== rtl/core/huffman_code_encoder_packer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_code_encoder_packer_core
// Huffman encoder with bit packing: table load, symbol encode and flush.
// ----------------------------------------------------------------------------
// Use:
//   Input items arrive on in_valid_i / in_item_i and are taken at an edge
//   where in_stall_o is low. A load item writes one code table entry; an
//   encode item looks up its symbol and appends the code to the pending
//   bits; a flush item emits the padded last byte or an end marker.
//   Results leave on out_valid_o / out_item_o, one byte per item, and are
//   taken at an edge where out_stall_i is low; last marks the final result
//   of an input item.
// Flow and throughput:
//   The taking edge reads the table into the lookup stage; the packed burst
//   is loaded into the output register when the emitter has room. Items
//   follow one per cycle while out_stall_i is low and no item gives more than
//   one result; an encode item that completes k bytes (up to four) holds the
//   byte-wide output until all k are taken. The table memory has one port per
//   cycle and needs no forwarding.
// Reset:
//   Clears all present flags, the pending bits and the bit total at once.
//   The code table contents need no clearing pass.
// Stalls:
//   While out_stall_i is high the shown result holds; the packer keeps one
//   item waiting and in_stall_o rises once that stage is occupied.
// ----------------------------------------------------------------------------
module huffman_code_encoder_packer_core
  import hcep_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire hcep_in_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output hcep_out_t      out_item_o
);

  logic        take;
  logic        look_valid;
  hcep_look_t  look;
  logic        advance;
  logic        burst_load;
  hcep_burst_t burst;
  logic        emit_free;

  // Input handshake: stall while the lookup stage cannot move on
  assign in_stall_o = look_valid && !advance;
  assign take       = in_valid_i && !in_stall_o;

  hcep_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .item_i       (in_item_i),
    .advance_i    (advance),
    .look_valid_o (look_valid),
    .look_o       (look)
  );

  hcep_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .look_valid_i (look_valid),
    .look_i       (look),
    .emit_free_i  (emit_free),
    .advance_o    (advance),
    .burst_load_o (burst_load),
    .burst_o      (burst)
  );

  hcep_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (burst_load),
    .burst_i      (burst),
    .out_stall_i  (out_stall_i),
    .free_o       (emit_free),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o)
  );

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman encoder and bit packer core. Directed
// items cover an empty table, the code length extremes, entry removal and
// both kinds of flush. A random stream of loads, encodes and flushes
// follows, with random gaps and output stalls and one long receiver
// hold-off. Every result is checked against a local model of the table, the
// pending bits and the bit total.
// ----------------------------------------------------------------------------
module tb;
  import hcep_pkg::*;

  localparam int ClkPeriod     = 20;
  localparam int ResetCycles   = 10;
  localparam int RandomItems   = 208;
  localparam int HoldItems     = 20;
  localparam int HoldCycles    = 200;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 2000;
  localparam int PoolSize      = 12;

  // The fourth request code is not in the package enum
  localparam logic [1:0]        ReqUnused = 2'd3;
  localparam logic [TotalW-1:0] TotalMax  = '1;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  hcep_in_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  hcep_out_t out_item_o;

  huffman_code_encoder_packer_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Model state: code table, pending bits and running total
  logic             tbl_present [SymbolCount];
  logic [LenW-1:0]  tbl_len     [SymbolCount];
  logic [CodeW-1:0] tbl_code    [SymbolCount];
  logic [6:0]        pend_bits = '0;
  logic [2:0]        pend_cnt  = '0;
  logic [TotalW-1:0] bit_sum   = '0;

  // Results still owed by the block, oldest first
  hcep_out_t owed_results [$];

  // Sender and receiver control
  bit no_gaps   = 1'b0;
  int calm_left = 0;
  bit hold_req  = 1'b0;
  bit holding   = 1'b0;

  // Run statistics
  int fail_cnt    = 0;
  int idle_cycles = 0;
  int n_loads     = 0;
  int n_encodes   = 0;
  int n_missing   = 0;
  int n_flushes   = 0;
  int n_unused    = 0;
  int n_results   = 0;
  int n_bytes     = 0;
  int n_holds     = 0;

  initial begin
    for (int s = 0; s < SymbolCount; s++) begin
      tbl_present[s] = 1'b0;
      tbl_len[s]     = '0;
      tbl_code[s]    = '0;
    end
  end

  function automatic hcep_out_t make_result(input logic [7:0] b, input kind_e k,
                                            input logic [TotalW-1:0] tot,
                                            input logic lst);
    hcep_out_t r;
    r.out_byte    = b;
    r.result_kind = k;
    r.bit_total   = tot;
    r.last        = lst;
    return r;
  endfunction

  // Work out the results of one accepted item and advance the model state
  task automatic predict_item(input hcep_in_t it);
    hcep_out_t       res [4];
    logic [7:0]      acc;
    logic [3:0]      cnt;
    logic [LenW-1:0] len;
    logic [7:0]      pad;
    int              s;
    int              n;
    s = int'(it.symbol);
    n = 0;
    case (it.req_type)
      REQ_LOAD: begin
        n_loads++;
        if (s < SymbolCount) begin
          len            = (it.code_length > CapLen) ? LenW'(CapLen) : it.code_length;
          tbl_present[s] = it.entry_present;
          tbl_len[s]     = len;
          tbl_code[s]    = it.code_bits;
        end
      end
      REQ_ENCODE: begin
        n_encodes++;
        if (s >= SymbolCount || !tbl_present[s]) begin
          n_missing++;
          owed_results.push_back(make_result(8'h00, KIND_MISSING, bit_sum, 1'b1));
        end else begin
          len = tbl_len[s];
          if (bit_sum > TotalMax - len) bit_sum = TotalMax;
          else bit_sum = bit_sum + len;
          acc = {1'b0, pend_bits};
          cnt = {1'b0, pend_cnt};
          for (int i = int'(len); i > 0; i--) begin
            acc = {acc[6:0], tbl_code[s][i-1]};
            cnt++;
            if (cnt == 4'd8) begin
              if (n < 4) begin
                res[n] = make_result(acc, KIND_BYTE, bit_sum, 1'b0);
                n++;
              end
              acc = '0;
              cnt = '0;
            end
          end
          pend_bits = acc[6:0];
          pend_cnt  = cnt[2:0];
          if (n > 0) res[n-1].last = 1'b1;
          for (int k = 0; k < n; k++) owed_results.push_back(res[k]);
        end
      end
      REQ_FLUSH: begin
        n_flushes++;
        if (pend_cnt != 3'd0) begin
          pad = {1'b0, pend_bits} << (4'd8 - pend_cnt);
          owed_results.push_back(make_result(pad, KIND_PAD, bit_sum, 1'b1));
        end else begin
          owed_results.push_back(make_result(8'h00, KIND_END, bit_sum, 1'b1));
        end
        pend_bits = '0;
        pend_cnt  = '0;
        bit_sum   = '0;
      end
      default: n_unused++;
    endcase
  endtask

  // Sender gap: mostly none or short, sometimes long, with calm stretches
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(15, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one item and wait for the block to take it; valid stays high so
  // that a following item can go out in the cycle right after
  task automatic send_item(input hcep_in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_item(it);
  endtask

  function automatic hcep_in_t load_item(input logic [7:0] sym, input logic [CodeW-1:0] code,
                                         input logic [LenW-1:0] len, input logic pres);
    hcep_in_t it;
    it.req_type      = REQ_LOAD;
    it.symbol        = sym;
    it.code_bits     = code;
    it.code_length   = len;
    it.entry_present = pres;
    return it;
  endfunction

  // Load with a random code; lengths lean short, with full and oversized ones
  function automatic hcep_in_t random_load(input logic [7:0] sym, input logic pres);
    int              r;
    logic [LenW-1:0] len;
    r = $urandom_range(0, 99);
    if (r < 10) len = 6'd32;
    else if (r < 15) len = LenW'($urandom_range(33, 63));
    else if (r < 20) len = 6'd0;
    else len = LenW'($urandom_range(1, 16));
    return load_item(sym, $urandom, len, pres);
  endfunction

  // Encode, flush and unused requests carry random values in unused fields
  function automatic hcep_in_t other_item(input logic [1:0] req, input logic [7:0] sym);
    hcep_in_t it;
    it.req_type      = req;
    it.symbol        = sym;
    it.code_bits     = $urandom;
    it.code_length   = LenW'($urandom_range(0, 63));
    it.entry_present = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Nothing loaded yet: every symbol is missing, flush gives the end marker
  task automatic test_empty_table();
    send_item(other_item(REQ_ENCODE, 8'h00));
    send_item(other_item(REQ_ENCODE, 8'hFF));
    send_item(other_item(ReqUnused, 8'h5A));
    send_item(other_item(REQ_FLUSH, 8'h00));
  endtask

  // Length extremes, oversized length, zero length, removal, both flushes
  task automatic test_code_extremes();
    send_item(load_item(8'h00, 32'hFFFF_FFFF, 6'd32, 1'b1));
    send_item(load_item(8'hFF, 32'h0000_0000, 6'd1, 1'b1));
    send_item(load_item(8'h80, 32'hDEAD_BEEF, 6'd0, 1'b1));
    send_item(load_item(8'h55, 32'hA5C3_3C5A, 6'd63, 1'b1));
    send_item(load_item(8'hAA, 32'hFFFF_FF7F, 6'd7, 1'b1));
    send_item(other_item(REQ_ENCODE, 8'hFF));
    send_item(other_item(REQ_ENCODE, 8'h00));
    send_item(other_item(REQ_ENCODE, 8'h80));
    send_item(other_item(REQ_ENCODE, 8'h55));
    send_item(other_item(REQ_FLUSH, 8'hFF));
    send_item(load_item(8'h55, 32'h0000_0000, 6'd0, 1'b0));
    send_item(other_item(REQ_ENCODE, 8'h55));
    send_item(other_item(REQ_ENCODE, 8'hAA));
    send_item(other_item(REQ_FLUSH, 8'h00));
    send_item(other_item(REQ_FLUSH, 8'h00));
  endtask

  // Mostly encodes of a loaded working set, with reloads, removals,
  // unknown symbols, flushes and unused requests mixed in
  task automatic test_random_stream();
    logic [7:0] pool [PoolSize];
    int         r;
    for (int k = 0; k < PoolSize; k++) begin
      pool[k] = 8'($urandom_range(0, 255));
      send_item(random_load(pool[k], 1'b1));
    end
    for (int k = 0; k < RandomItems; k++) begin
      r = $urandom_range(0, 99);
      if (r < 60) send_item(other_item(REQ_ENCODE, pool[$urandom_range(0, PoolSize - 1)]));
      else if (r < 70) send_item(other_item(REQ_ENCODE, 8'($urandom_range(0, 255))));
      else if (r < 80)
        send_item(random_load(pool[$urandom_range(0, PoolSize - 1)],
                              $urandom_range(0, 99) < 85));
      else if (r < 84)
        send_item(random_load(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      else if (r < 94) send_item(other_item(REQ_FLUSH, 8'($urandom_range(0, 255))));
      else send_item(other_item(ReqUnused, 8'($urandom_range(0, 255))));
    end
  endtask

  // Receiver holds off while full-length codes arrive back to back
  task automatic test_receiver_holdoff();
    send_item(load_item(8'hC3, $urandom, 6'd32, 1'b1));
    in_valid_i <= 1'b0;
    hold_req = 1'b1;
    while (!holding) @(posedge clk_i);
    no_gaps = 1'b1;
    for (int k = 0; k < HoldItems; k++) send_item(other_item(REQ_ENCODE, 8'hC3));
    no_gaps = 1'b0;
    send_item(other_item(REQ_FLUSH, 8'h00));
  endtask

  // Receiver: random stall pattern, or a long hold-off on request
  initial begin : receiver
    int run;
    int r;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        n_holds++;
        out_stall_i <= 1'b1;
        run = HoldCycles;
      end else begin
        holding = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_stall_i <= 1'b0;
          run = $urandom_range(1, 6);
        end else if (r < 75) begin
          out_stall_i <= 1'b1;
          run = $urandom_range(1, 3);
        end else if (r < 90) begin
          out_stall_i <= 1'b0;
          run = $urandom_range(10, 40);
        end else begin
          out_stall_i <= 1'b1;
          run = $urandom_range(6, 25);
        end
      end
      repeat (run) @(posedge clk_i);
    end
  end

  // Result check and watchdog
  always @(posedge clk_i) begin : result_check
    hcep_out_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (owed_results.size() == 0) begin
          $error("unexpected result: out_byte %0h kind %0d total %0d last %0b",
                 out_item_o.out_byte, out_item_o.result_kind, out_item_o.bit_total,
                 out_item_o.last);
          fail_cnt++;
        end else begin
          want = owed_results.pop_front();
          if (want.result_kind == KIND_BYTE) n_bytes++;
          if (out_item_o.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_item_o.out_byte);
            fail_cnt++;
          end
          if (out_item_o.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   out_item_o.result_kind);
            fail_cnt++;
          end
          if (out_item_o.bit_total !== want.bit_total) begin
            $error("bit_total: expected %0d, got %0d", want.bit_total, out_item_o.bit_total);
            fail_cnt++;
          end
          if (out_item_o.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_item_o.last);
            fail_cnt++;
          end
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                 idle_cycles, owed_results.size());
        $display("huffman_code_encoder_packer_core test failed");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_code_extremes();
    test_random_stream();
    test_receiver_holdoff();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d loads, %0d encodes (%0d without a code), %0d flushes, %0d unused",
             n_loads, n_encodes, n_missing, n_flushes, n_unused);
    $display("Checked %0d results (%0d full bytes) across %0d long receiver hold-offs",
             n_results, n_bytes, n_holds);
    if (fail_cnt == 0) begin
      $display("huffman_code_encoder_packer_core test passed");
    end else begin
      $display("huffman_code_encoder_packer_core test failed");
    end
    $finish;
  end

endmodule
